/* hw/rtl/cbbp_pkg.sv */
// Shared types and constants for the cluster barrier and boot peripheral.
// No dependencies; every file but the two channel interfaces imports this package.
`timescale 1ns / 1ps

package cbbp_pkg;

  // Core set
  localparam int MAX_CORES = 16;
  localparam int CORE_W    = 4;

  // Item kinds
  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Register byte offsets
  localparam logic [11:0] OFF_BARRIER = 12'h000;
  localparam logic [11:0] OFF_BOOT    = 12'h010;
  localparam logic [11:0] OFF_EXIT    = 12'h014;
  localparam logic [3:0]  ACCESS_WORD = 4'd4;

  // Result kinds
  localparam logic [1:0] KIND_REPLY   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_WAKE    = 2'd2;

  // Configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CORE_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_DELAY    = 2'd2;
  localparam logic [4:0] CORE_COUNT_RESET = 5'd16;

  // Job queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One job: the results caused by one input word, in emission order:
  // access reply, then wake, then releases in ascending core order.
  typedef struct packed {
    logic                 reply;
    logic [CORE_W-1:0]    core;
    logic [31:0]          rd;
    logic                 ev;
    logic [30:0]          code;
    logic                 wake;
    logic [MAX_CORES-1:0] rel;
  } cbbp_job_t;

endpackage

/* hw/rtl/cbbp_in_if.sv */
// Input channel: bus accesses and clock ticks.
// Depends on nothing.
`timescale 1ns / 1ps

interface cbbp_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [3:0]  initiator;
  logic        write_flag;
  logic [11:0] offset;
  logic [3:0]  access_bytes;
  logic [31:0] write_value;

  modport source (output valid, cmd, initiator, write_flag, offset, access_bytes,
                  write_value, input ready);
  modport sink (input valid, cmd, initiator, write_flag, offset, access_bytes,
                write_value, output ready);
endinterface

/* hw/rtl/cbbp_out_if.sv */
// Result channel: access replies, barrier releases and boot wakes.
// Depends on nothing.
`timescale 1ns / 1ps

interface cbbp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  reply_core;
  logic [1:0]  reply_kind;
  logic [31:0] read_value;
  logic        exit_valid;
  logic [30:0] exit_status;
  logic        last;

  modport source (output valid, reply_core, reply_kind, read_value, exit_valid,
                  exit_status, last, input ready);
  modport sink (input valid, reply_core, reply_kind, read_value, exit_valid,
                exit_status, last, output ready);
endinterface

/* hw/rtl/cbbp_front.sv */
// Front end: accepts input words, updates barrier, boot and exit state,
// and builds one job per word that causes results. Uses cbbp_pkg, cbbp_in_if.
`timescale 1ns / 1ps

module cbbp_front import cbbp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  cbbp_in_if.sink               in_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_full,
  output logic                  q_push,
  output cbbp_job_t             q_job
);

  logic [4:0]           core_count_r;
  logic [15:0]          release_delay_r;
  logic [15:0]          boot_delay_r;

  logic [MAX_CORES-1:0] parked_mask_r, parked_mask_nxt;
  logic [4:0]           parked_total_r, parked_total_nxt;
  logic                 armed_r, armed_nxt;
  logic [15:0]          release_cnt_r, release_cnt_nxt;
  logic [31:0]          boot_word_r, boot_word_nxt;
  logic                 boot_started_r, boot_started_nxt;
  logic [15:0]          boot_cnt_r, boot_cnt_nxt;
  logic                 exit_seen_r, exit_seen_nxt;

  logic                 accept;
  logic                 in_range;
  logic [MAX_CORES-1:0] join_mask;
  logic [4:0]           total_inc;
  logic [4:0]           need;
  logic [15:0]          rel_dec;
  cbbp_job_t            job;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_range    = ({1'b0, in_ch.initiator} < (CORE_W+1)'(MAX_CORES));
  assign join_mask   = parked_mask_r | (MAX_CORES'(1) << in_ch.initiator);
  assign total_inc   = parked_total_r + 5'd1;
  assign need        = (core_count_r == 5'd0) ? 5'd1 : core_count_r;
  assign rel_dec     = (release_cnt_r != 16'd0) ? release_cnt_r - 16'd1 : 16'd0;

  // Classify the word and work out next state and the job it causes
  always_comb begin
    parked_mask_nxt  = parked_mask_r;
    parked_total_nxt = parked_total_r;
    armed_nxt        = armed_r;
    release_cnt_nxt  = release_cnt_r;
    boot_word_nxt    = boot_word_r;
    boot_started_nxt = boot_started_r;
    boot_cnt_nxt     = boot_cnt_r;
    exit_seen_nxt    = exit_seen_r;
    job              = '0;

    if (in_ch.cmd == CMD_TICK) begin
      // Advance boot countdown, wake on reaching zero
      if (boot_cnt_r != 16'd0) begin
        boot_cnt_nxt = boot_cnt_r - 16'd1;
        if (boot_cnt_r == 16'd1) job.wake = 1'b1;
      end
      // Advance release countdown, release everyone on zero
      if (armed_r) begin
        release_cnt_nxt = rel_dec;
        if (rel_dec == 16'd0) begin
          job.rel          = parked_mask_r;
          parked_mask_nxt  = '0;
          parked_total_nxt = '0;
          armed_nxt        = 1'b0;
        end
      end
    end else if (in_ch.offset == OFF_BARRIER && !in_ch.write_flag) begin
      // Park the core; drop repeats and out-of-range cores
      if (in_range && !parked_mask_r[in_ch.initiator]) begin
        parked_mask_nxt  = join_mask;
        parked_total_nxt = total_inc;
        if (!armed_r && total_inc >= need) begin
          armed_nxt       = 1'b1;
          release_cnt_nxt = release_delay_r;
          if (release_delay_r == 16'd0) begin
            job.rel          = join_mask;
            parked_mask_nxt  = '0;
            parked_total_nxt = '0;
            armed_nxt        = 1'b0;
          end
        end
      end
    end else begin
      // Plain register access: one reply to the initiator
      job.reply = 1'b1;
      job.core  = in_ch.initiator;
      if (in_ch.offset == OFF_BOOT && in_ch.access_bytes == ACCESS_WORD) begin
        if (in_ch.write_flag) begin
          boot_word_nxt = in_ch.write_value;
          if (in_ch.write_value != 32'd0 && !boot_started_r) begin
            boot_started_nxt = 1'b1;
            if (boot_delay_r == 16'd0) job.wake = 1'b1;
            else boot_cnt_nxt = boot_delay_r;
          end
        end else begin
          job.rd = boot_word_r;
        end
      end else if (in_ch.offset == OFF_EXIT && in_ch.write_flag &&
                   in_ch.access_bytes == ACCESS_WORD) begin
        if (in_ch.write_value[0] && !exit_seen_r) begin
          exit_seen_nxt = 1'b1;
          job.ev        = 1'b1;
          job.code      = in_ch.write_value[31:1];
        end
      end
    end
  end

  assign q_job  = job;
  assign q_push = accept && (job.reply || job.wake || (job.rel != '0));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_count_r    <= CORE_COUNT_RESET;
      release_delay_r <= '0;
      boot_delay_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CORE_COUNT:    core_count_r    <= cfg_data[4:0];
        CFG_RELEASE_DELAY: release_delay_r <= cfg_data;
        CFG_BOOT_DELAY:    boot_delay_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Block state, updated only on an accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parked_mask_r  <= '0;
      parked_total_r <= '0;
      armed_r        <= 1'b0;
      release_cnt_r  <= '0;
      boot_word_r    <= '0;
      boot_started_r <= 1'b0;
      boot_cnt_r     <= '0;
      exit_seen_r    <= 1'b0;
    end else if (accept) begin
      parked_mask_r  <= parked_mask_nxt;
      parked_total_r <= parked_total_nxt;
      armed_r        <= armed_nxt;
      release_cnt_r  <= release_cnt_nxt;
      boot_word_r    <= boot_word_nxt;
      boot_started_r <= boot_started_nxt;
      boot_cnt_r     <= boot_cnt_nxt;
      exit_seen_r    <= exit_seen_nxt;
    end
  end

endmodule

/* hw/rtl/cbbp_job_fifo.sv */
// Short job queue between front and back end.
// Uses cbbp_pkg for the job type and depth.
`timescale 1ns / 1ps

module cbbp_job_fifo import cbbp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cbbp_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output cbbp_job_t pop_job
);

  cbbp_job_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]       count_r;

  assign full      = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_job   = slot_r[rd_ptr_r];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      unique case ({push, pop})
        2'b10:   count_r <= count_r + (QPTR_W+1)'(1);
        2'b01:   count_r <= count_r - (QPTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* hw/rtl/cbbp_back.sv */
// Back end: takes jobs from the queue and sends their results one word per cycle, while
// the result side is ready, through an output register. Uses cbbp_pkg, cbbp_out_if.
`timescale 1ns / 1ps

module cbbp_back import cbbp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_not_empty,
  input  cbbp_job_t q_job,
  output logic      q_pop,
  cbbp_out_if.source out_ch
);

  cbbp_job_t            job_r, job_nxt, job_left;
  logic                 busy, advance, rest_empty, load;
  logic [CORE_W-1:0]    low_idx;

  logic                 out_valid_r;
  logic [3:0]           core_r,  core_nxt;
  logic [1:0]           kind_r,  kind_nxt;
  logic [31:0]          rd_r,    rd_nxt;
  logic                 ev_r,    ev_nxt;
  logic [30:0]          code_r,  code_nxt;
  logic                 last_r;

  assign busy    = job_r.reply || job_r.wake || (job_r.rel != '0);
  assign load    = !out_valid_r || out_ch.ready;
  assign advance = load && busy;

  // Lowest parked core still to release
  always_comb begin
    low_idx = '0;
    for (int i = MAX_CORES - 1; i >= 0; i--) begin
      if (job_r.rel[i]) low_idx = CORE_W'(i);
    end
  end

  // Pick the next result and what remains of the job
  always_comb begin
    job_left = job_r;
    core_nxt = '0;
    kind_nxt = KIND_RELEASE;
    rd_nxt   = '0;
    ev_nxt   = 1'b0;
    code_nxt = '0;
    if (job_r.reply) begin
      job_left.reply = 1'b0;
      core_nxt       = job_r.core;
      kind_nxt       = KIND_REPLY;
      rd_nxt         = job_r.rd;
      ev_nxt         = job_r.ev;
      code_nxt       = job_r.code;
    end else if (job_r.wake) begin
      job_left.wake = 1'b0;
      kind_nxt      = KIND_WAKE;
    end else begin
      job_left.rel = job_r.rel & (job_r.rel - MAX_CORES'(1));
      core_nxt     = low_idx;
    end
  end

  assign rest_empty = !job_left.reply && !job_left.wake && (job_left.rel == '0);
  assign q_pop      = q_not_empty && (!busy || (advance && rest_empty));

  always_comb begin
    if (q_pop)        job_nxt = q_job;
    else if (advance) job_nxt = job_left;
    else              job_nxt = job_r;
  end

  // Hold the current job
  always_ff @(posedge clk) begin
    if (!rst_n) job_r <= '0;
    else        job_r <= job_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      core_r <= core_nxt;
      kind_r <= kind_nxt;
      rd_r   <= rd_nxt;
      ev_r   <= ev_nxt;
      code_r <= code_nxt;
      last_r <= rest_empty;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.reply_core  = core_r;
  assign out_ch.reply_kind  = kind_r;
  assign out_ch.read_value  = rd_r;
  assign out_ch.exit_valid  = ev_r;
  assign out_ch.exit_status = code_r;
  assign out_ch.last        = last_r;

endmodule

/* hw/rtl/cluster_barrier_boot_peripheral.sv */
// Top level of the cluster barrier and boot peripheral.
// Uses cbbp_pkg, cbbp_in_if, cbbp_out_if, cbbp_front, cbbp_job_fifo, cbbp_back.
//
//   channel | dir | handshake          | word
//   in_ch   | in  | valid/ready        | cmd, initiator, write_flag, offset, bytes, data
//   out_ch  | out | valid/ready        | core, kind, read data, exit flag/code, last
//   cfg_*   | in  | cfg_we, no stall   | index, 16-bit data
//
// The front end takes one input word per cycle while the two-job queue has room;
// state updates land in the cycle the word is taken.
// The back end sends one result word per cycle while out_ch is ready; a job has 1 to 17 words
// (a barrier release sends one word per parked core), and that burst sets the rate.
// Reset (rst_n low, synchronous) clears all state and loads the config defaults.
// Either side may stall on its own; the queue and output register absorb it.
`timescale 1ns / 1ps

module cluster_barrier_boot_peripheral import cbbp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  cbbp_in_if.sink               in_ch,
  cbbp_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic      q_full, q_push, q_pop, q_not_empty;
  cbbp_job_t push_job, pop_job;

  cbbp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  cbbp_job_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_job   (pop_job)
  );

  cbbp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_job       (pop_job),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

/* sim/cbbp_reply_checker.sv */
// Checker for the cluster barrier and boot peripheral: watches the input, result and
// configuration ports, predicts every result word and compares it field by field.
// Depends on cbbp_pkg, cbbp_in_if and cbbp_out_if.
`timescale 1ns / 1ps

module cbbp_reply_checker import cbbp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  cbbp_in_if                    in_mon,
  cbbp_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    outstanding,
  output int                    results_checked,
  output int                    releases_checked,
  output int                    wakes_checked
);

  typedef struct packed {
    logic [3:0]  core;
    logic [1:0]  kind;
    logic [31:0] data;
    logic        ev;
    logic [30:0] code;
    logic        last;
  } reply_t;

  // Predicted result words, oldest first
  reply_t expected_replies[$];

  // Shadow configuration
  logic [4:0]  need_count;
  logic [15:0] rel_delay;
  logic [15:0] wake_delay;

  // Shadow block state
  logic [MAX_CORES-1:0] parked;
  logic [4:0]           parked_n;
  logic                 armed;
  logic [15:0]          rel_left;
  logic [31:0]          boot_word;
  logic                 booted;
  logic [16:0]          boot_left;
  logic                 exit_done;

  int     mismatches;
  reply_t got;
  reply_t want;

  assign fail_count = mismatches;

  task automatic clear_model();
    need_count = CORE_COUNT_RESET;
    rel_delay  = '0;
    wake_delay = '0;
    parked     = '0;
    parked_n   = '0;
    armed      = 1'b0;
    rel_left   = '0;
    boot_word  = '0;
    booted     = 1'b0;
    boot_left  = '0;
    exit_done  = 1'b0;
    expected_replies.delete();
  endtask

  task automatic push_reply(input logic [3:0] core, input logic [1:0] kind,
                            input logic [31:0] data, input logic ev,
                            input logic [30:0] code);
    reply_t r;
    r.core = core;
    r.kind = kind;
    r.data = data;
    r.ev   = ev;
    r.code = code;
    r.last = 1'b0;
    expected_replies.insert(expected_replies.size(), r);
  endtask

  // Release every parked core in ascending order and disarm
  task automatic release_parked();
    for (int i = 0; i < MAX_CORES; i++) begin
      if (parked[i]) push_reply(i[3:0], KIND_RELEASE, '0, 1'b0, '0);
    end
    parked   = '0;
    parked_n = '0;
    armed    = 1'b0;
    rel_left = '0;
  endtask

  // Work out the result words caused by one accepted input word
  task automatic predict_word(input logic cmd, input logic [3:0] core, input logic wr,
                              input logic [11:0] off, input logic [3:0] nbytes,
                              input logic [31:0] value);
    int          first;
    logic [31:0] rd;
    logic        ev;
    logic [30:0] code;
    logic        wake;
    logic [4:0]  need;
    first = expected_replies.size();
    rd    = '0;
    ev    = 1'b0;
    code  = '0;
    wake  = 1'b0;
    if (cmd == CMD_TICK) begin
      // wake first, then releases
      if (boot_left != 0) begin
        boot_left = boot_left - 1'b1;
        if (boot_left == 0) push_reply(4'd0, KIND_WAKE, '0, 1'b0, '0);
      end
      if (armed) begin
        if (rel_left != 0) rel_left = rel_left - 1'b1;
        if (rel_left == 0) release_parked();
      end
    end else if (off == OFF_BARRIER && !wr) begin
      // park the core; no reply until release
      if (core < MAX_CORES && !parked[core]) begin
        need = (need_count == 0) ? 5'd1 : need_count;
        parked[core] = 1'b1;
        parked_n     = parked_n + 1'b1;
        if (!armed && parked_n >= need) begin
          armed    = 1'b1;
          rel_left = rel_delay;
          if (rel_delay == 0) release_parked();
        end
      end
    end else begin
      if (off == OFF_BOOT && nbytes == ACCESS_WORD) begin
        if (wr) begin
          boot_word = value;
          if (value != 0 && !booted) begin
            booted = 1'b1;
            if (wake_delay == 0) wake = 1'b1;
            else boot_left = {1'b0, wake_delay};
          end
        end else begin
          rd = boot_word;
        end
      end else if (off == OFF_EXIT && wr && nbytes == ACCESS_WORD) begin
        if (value[0] && !exit_done) begin
          exit_done = 1'b1;
          ev        = 1'b1;
          code      = value[31:1];
        end
      end
      push_reply(core, KIND_REPLY, rd, ev, code);
      if (wake) push_reply(4'd0, KIND_WAKE, '0, 1'b0, '0);
    end
    // mark the final word of this input
    if (expected_replies.size() > first) begin
      expected_replies[expected_replies.size() - 1].last = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
    end else begin
      // apply register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_CORE_COUNT:    need_count = cfg_data[4:0];
          CFG_RELEASE_DELAY: rel_delay  = cfg_data;
          CFG_BOOT_DELAY:    wake_delay = cfg_data;
          default: ;
        endcase
      end

      // predict on every accepted input word
      if (in_mon.valid && in_mon.ready) begin
        predict_word(in_mon.cmd, in_mon.initiator, in_mon.write_flag, in_mon.offset,
                     in_mon.access_bytes, in_mon.write_value);
      end

      // compare every accepted result word with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got.core = out_mon.reply_core;
        got.kind = out_mon.reply_kind;
        got.data = out_mon.read_value;
        got.ev   = out_mon.exit_valid;
        got.code = out_mon.exit_status;
        got.last = out_mon.last;
        results_checked++;
        if (got.kind == KIND_RELEASE) releases_checked++;
        if (got.kind == KIND_WAKE) wakes_checked++;
        if (expected_replies.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result word: core %0d kind %0d data %h exit %0b code %h last %0b",
                     got.core, got.kind, got.data, got.ev, got.code, got.last);
          end
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          if (got != want) begin
            if (mismatches < 10) begin
              $display("mismatch: expected core %0d kind %0d data %h exit %0b code %h last %0b",
                       want.core, want.kind, want.data, want.ev, want.code, want.last);
              $display("          actual   core %0d kind %0d data %h exit %0b code %h last %0b",
                       got.core, got.kind, got.data, got.ev, got.code, got.last);
            end
            mismatches++;
          end
        end
      end
    end
    outstanding <= expected_replies.size();
  end

endmodule

/* sim/cluster_barrier_boot_peripheral_test.sv */
// Testbench top for the cluster barrier and boot peripheral: clock, reset, stimulus,
// result-side pacing and the verdict. Depends on cbbp_pkg, both channel interfaces,
// the block itself and cbbp_reply_checker.
`timescale 1ns / 1ps

module cluster_barrier_boot_peripheral_test;
  import cbbp_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 2000000;
  localparam int          SETTLE_CYCLES   = 24;
  localparam int          HOLD_OFF_CYCLES = 400;
  localparam int          PHASE_WORDS     = 56;
  localparam int          NUM_PHASES      = 6;
  localparam int          EQUAL_DELAY     = 40;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  initiator;
    logic        wr;
    logic [11:0] offset;
    logic [3:0]  nbytes;
    logic [31:0] value;
  } in_word_t;

  // Register settings of the random phases
  int phase_count [NUM_PHASES] = '{1, 16, 0, 5, 2, 8};
  int phase_rel   [NUM_PHASES] = '{0, 0, 3, 1, 40, 0};
  int phase_boot  [NUM_PHASES] = '{0, 65535, 7, 1, 0, 100};

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int outstanding;
  int results_checked;
  int releases_checked;
  int wakes_checked;
  int words_sent;
  int settings_used;
  bit hold_off_req;

  cbbp_in_if  in_ch();
  cbbp_out_if out_ch();

  cluster_barrier_boot_peripheral dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cbbp_reply_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .outstanding      (outstanding),
    .results_checked  (results_checked),
    .releases_checked (releases_checked),
    .wakes_checked    (wakes_checked)
  );

  always #10 clk = ~clk;

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_word_t make_access(input logic [3:0] core, input logic wr,
                                           input logic [11:0] off, input logic [3:0] nbytes,
                                           input logic [31:0] value);
    in_word_t w;
    w.cmd       = CMD_ACCESS;
    w.initiator = core;
    w.wr        = wr;
    w.offset    = off;
    w.nbytes    = nbytes;
    w.value     = value;
    return w;
  endfunction

  // Tick with random content in the unused fields
  function automatic in_word_t make_tick();
    in_word_t w;
    w = make_access(4'($urandom_range(15)), 1'($urandom_range(1)),
                    12'($urandom_range(4095)), 4'($urandom_range(1, 8)), $urandom());
    w.cmd = CMD_TICK;
    return w;
  endfunction

  // Random word: mostly well-formed register traffic and ticks, some noise
  function automatic in_word_t make_random_word();
    in_word_t w;
    int       r;
    logic [3:0] sz;
    r  = $urandom_range(99);
    sz = ($urandom_range(9) == 0) ? 4'($urandom_range(1, 8)) : ACCESS_WORD;
    if (r < 35) begin
      w = make_tick();
    end else if (r < 62) begin
      w = make_access(4'($urandom_range(15)), 1'b0, OFF_BARRIER,
                      4'($urandom_range(1, 8)), $urandom());
    end else if (r < 72) begin
      w = make_access(4'($urandom_range(15)), 1'b1, OFF_BOOT, sz,
                      ($urandom_range(4) == 0) ? 32'd0 : $urandom());
    end else if (r < 78) begin
      w = make_access(4'($urandom_range(15)), 1'b0, OFF_BOOT, sz, $urandom());
    end else if (r < 84) begin
      w = make_access(4'($urandom_range(15)), 1'b1, OFF_EXIT, sz, $urandom());
    end else if (r < 88) begin
      w = make_access(4'($urandom_range(15)), 1'b1, OFF_BARRIER, sz, $urandom());
    end else begin
      w = make_access(4'($urandom_range(15)), 1'($urandom_range(1)),
                      12'($urandom_range(4095)), 4'($urandom_range(1, 8)), $urandom());
    end
    return w;
  endfunction

  // Offer one word and hold it until the block takes it; valid stays high after
  task automatic offer_word(input in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= w.cmd;
    in_ch.initiator    <= w.initiator;
    in_ch.write_flag   <= w.wr;
    in_ch.offset       <= w.offset;
    in_ch.access_bytes <= w.nbytes;
    in_ch.write_value  <= w.value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // Drop valid, wait for every predicted word, then let the block go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic apply_setting(input int count, input int rel, input int boot);
    cfg_write(CFG_CORE_COUNT, count);
    cfg_write(CFG_RELEASE_DELAY, rel);
    cfg_write(CFG_BOOT_DELAY, boot);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin : result_pacing
    int gap;
    int run;
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req && !held) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        held = 1'b1;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        run = $urandom_range(1, 12);
        repeat (run) @(posedge clk);
      end
    end
  end

  // Stop a hung run
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("cycle limit reached with %0d results outstanding", outstanding);
    $display("cluster_barrier_boot_peripheral regression: fail");
    $finish;
  end

  initial begin : stimulus
    words_sent    = 0;
    settings_used = 1;
    hold_off_req  = 1'b0;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_CORE_COUNT;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.cmd          <= CMD_ACCESS;
    in_ch.initiator    <= '0;
    in_ch.write_flag   <= 1'b0;
    in_ch.offset       <= '0;
    in_ch.access_bytes <= '0;
    in_ch.write_value  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset settings: register corners and the exit flag
    offer_word(make_access(4'd3, 1'b0, OFF_BOOT, ACCESS_WORD, 32'h0));
    offer_word(make_access(4'd5, 1'b1, OFF_BOOT, ACCESS_WORD, 32'h0));
    offer_word(make_access(4'd7, 1'b1, OFF_BOOT, 4'd2, 32'hFFFF_FFFF));
    offer_word(make_access(4'd8, 1'b0, OFF_BOOT, 4'd8, 32'h0));
    offer_word(make_access(4'd0, 1'b0, OFF_EXIT, ACCESS_WORD, 32'hFFFF_FFFF));
    offer_word(make_access(4'd1, 1'b1, OFF_EXIT, ACCESS_WORD, 32'hFFFF_FFFE));
    offer_word(make_access(4'd2, 1'b1, OFF_EXIT, 4'd1, 32'h0000_0001));
    offer_word(make_access(4'd9, 1'b1, OFF_EXIT, ACCESS_WORD, 32'hFFFF_FFFF));
    offer_word(make_access(4'd4, 1'b1, OFF_EXIT, ACCESS_WORD, 32'h0000_0003));
    offer_word(make_access(4'd15, 1'b0, 12'hFFF, ACCESS_WORD, 32'h1234_5678));
    offer_word(make_access(4'd6, 1'b1, OFF_BARRIER, ACCESS_WORD, 32'hFFFF_FFFF));
    // Park all sixteen cores; the repeat from core 15 is ignored
    offer_word(make_access(4'd15, 1'b0, OFF_BARRIER, 4'd1, 32'h0));
    offer_word(make_access(4'd15, 1'b0, OFF_BARRIER, ACCESS_WORD, 32'h0));
    for (int i = 14; i >= 0; i--) begin
      offer_word(make_access(i[3:0], 1'b0, OFF_BARRIER, 4'((i % 8) + 1), 32'h0));
    end
    settle();

    // Equal delays: wake and release land on the same tick
    apply_setting(3, EQUAL_DELAY, EQUAL_DELAY);
    offer_word(make_access(4'd1, 1'b0, OFF_BARRIER, ACCESS_WORD, 32'h0));
    offer_word(make_access(4'd2, 1'b0, OFF_BARRIER, ACCESS_WORD, 32'h0));
    offer_word(make_access(4'd3, 1'b0, OFF_BARRIER, ACCESS_WORD, 32'h0));
    offer_word(make_access(4'd4, 1'b0, OFF_BARRIER, ACCESS_WORD, 32'h0));
    offer_word(make_access(4'd6, 1'b1, OFF_BOOT, ACCESS_WORD, 32'hA5A5_0001));
    offer_word(make_access(4'd6, 1'b0, OFF_BOOT, ACCESS_WORD, 32'h0));
    for (int i = 0; i < EQUAL_DELAY; i++) begin
      offer_word(make_tick());
    end
    settle();

    // Random phases over several register settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_setting(phase_count[p], phase_rel[p], phase_boot[p]);
      if (p == 0) hold_off_req = 1'b1;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        offer_word(make_random_word());
      end
      settle();
    end

    $display("ran %0d input words over %0d register settings", words_sent, settings_used);
    $display("checked %0d result words: %0d barrier releases, %0d boot wakes",
             results_checked, releases_checked, wakes_checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("cluster_barrier_boot_peripheral regression: pass");
    end else begin
      $display("cluster_barrier_boot_peripheral regression: fail");
    end
    $finish;
  end

endmodule
